>>> rtl/sais_pkg.sv
// shared types and constants of the suffix array interval search
`timescale 1ns / 1ps
`default_nettype none
package sais_pkg;

    // store depths and derived address widths
    localparam int TEXT_DEPTH = 65536;
    localparam int PAT_DEPTH  = 1024;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int PAT_AW     = $clog2(PAT_DEPTH);

    // field widths
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 16;
    localparam int TL_W     = 17;
    localparam int POS_W    = 17;
    localparam int ANCHOR_W = 10;
    localparam int PLEN_W   = 11;

    // packed word widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_TEXT    = 2'd0,
        CMD_SUFFIX  = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_SEARCH  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RC_LT = 2'd0,
        RC_EQ = 2'd1,
        RC_GT = 2'd2
    } rc_t;

    typedef enum logic [1:0] {
        IDX_LEFT  = 2'd0,
        IDX_RIGHT = 2'd1,
        IDX_MID   = 2'd2
    } idx_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_START,
        ST_CHK,
        ST_CHAR,
        ST_DECIDE,
        ST_LCHK,
        ST_UCHK,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        STEP_L0,
        STEP_L1,
        STEP_LLOOP,
        STEP_U0,
        STEP_U1,
        STEP_ULOOP
    } step_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load_query;
        logic     we_text;
        logic     we_suffix;
        logic     we_pat;
        idx_sel_t idx_sel;
        logic     from_min;
        logic     cmp_start;
        logic     eval_char;
        logic     end_cmp;
        logic     set_lp;
        logic     set_rp;
        logic     right_mid;
        logic     left_mid;
        logic     lres_right;
        logic     upper_init;
        logic     rres_left;
        logic     set_miss;
        logic     out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic l_done;
        logic char_ne;
        rc_t  rc;
        logic more;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/sais_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sais_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/sais_ctrl.sv
// controller state machine of the interval search
`timescale 1ns / 1ps
`default_nettype none
module sais_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output sais_pkg::dp_cmd_t       cmd,
    input  wire sais_pkg::dp_stat_t stat
);
    import sais_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   m_valid_reg, m_valid_next;
    cmd_t   in_cmd;

    assign in_cmd   = cmd_t'(s_tuser);
    assign m_tvalid = m_valid_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_L0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cmd.from_min = (step_reg == STEP_LLOOP) || (step_reg == STEP_ULOOP);
        case (step_reg)
            STEP_L0, STEP_U0: cmd.idx_sel = IDX_LEFT;
            STEP_L1, STEP_U1: cmd.idx_sel = IDX_RIGHT;
            default:          cmd.idx_sel = IDX_MID;
        endcase
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_TEXT:    cmd.we_text   = 1'b1;
                        CMD_SUFFIX:  cmd.we_suffix = 1'b1;
                        CMD_PATTERN: cmd.we_pat    = 1'b1;
                        default: begin
                            cmd.load_query = 1'b1;
                            step_next      = STEP_L0;
                            state_next     = ST_ADDR;
                        end
                    endcase
                end
            end
            ST_ADDR: state_next = ST_START;
            ST_START: begin
                cmd.cmp_start = 1'b1;
                state_next    = ST_CHK;
            end
            ST_CHK: begin
                if (stat.l_done) begin
                    cmd.end_cmp = 1'b1;
                    state_next  = ST_DECIDE;
                end else begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                cmd.eval_char = 1'b1;
                state_next    = stat.char_ne ? ST_DECIDE : ST_CHK;
            end
            ST_DECIDE: begin
                case (step_reg)
                    STEP_L0: begin
                        state_next = ST_ADDR;
                        if (stat.rc == RC_GT) begin
                            cmd.set_lp = 1'b1;
                            step_next  = STEP_L1;
                        end else begin
                            cmd.upper_init = 1'b1;
                            step_next      = STEP_U0;
                        end
                    end
                    STEP_L1: begin
                        if (stat.rc == RC_GT) begin
                            cmd.set_miss = 1'b1;
                            state_next   = ST_FIN;
                        end else begin
                            cmd.set_rp = 1'b1;
                            state_next = ST_LCHK;
                        end
                    end
                    STEP_LLOOP: begin
                        state_next = ST_LCHK;
                        if (stat.rc != RC_GT) begin
                            cmd.right_mid = 1'b1;
                            cmd.set_rp    = 1'b1;
                        end else begin
                            cmd.left_mid = 1'b1;
                            cmd.set_lp   = 1'b1;
                        end
                    end
                    STEP_U0: begin
                        if (stat.rc == RC_LT) begin
                            cmd.set_miss = 1'b1;
                            state_next   = ST_FIN;
                        end else begin
                            cmd.set_lp = 1'b1;
                            step_next  = STEP_U1;
                            state_next = ST_ADDR;
                        end
                    end
                    STEP_U1: begin
                        if (stat.rc == RC_LT) begin
                            cmd.set_rp = 1'b1;
                            state_next = ST_UCHK;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                    default: begin
                        state_next = ST_UCHK;
                        if (stat.rc != RC_LT) begin
                            cmd.left_mid = 1'b1;
                            cmd.set_lp   = 1'b1;
                        end else begin
                            cmd.right_mid = 1'b1;
                            cmd.set_rp    = 1'b1;
                        end
                    end
                endcase
            end
            ST_LCHK: begin
                state_next = ST_ADDR;
                if (stat.more) begin
                    step_next = STEP_LLOOP;
                end else begin
                    cmd.lres_right = 1'b1;
                    cmd.upper_init = 1'b1;
                    step_next      = STEP_U0;
                end
            end
            ST_UCHK: begin
                if (stat.more) begin
                    step_next  = STEP_ULOOP;
                    state_next = ST_ADDR;
                end else begin
                    cmd.rres_left = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = (m_valid_reg && !m_tready) || cmd.out_load;
    end
endmodule
`default_nettype wire

>>> rtl/sais_dp.sv
// datapath: stores, query registers, compare unit and result word
`timescale 1ns / 1ps
`default_nettype none
module sais_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sais_pkg::TL_W-1:0]          cfg_wr_data,
    input  wire logic [sais_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tuser,
    output logic      [sais_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire sais_pkg::dp_cmd_t                  cmd,
    output sais_pkg::dp_stat_t                      stat
);
    import sais_pkg::*;

    // unpacked input word
    logic [IDX_W-1:0]    in_addr, in_data, in_left, in_right, in_skip;
    logic [ANCHOR_W-1:0] in_anchor;
    logic [PLEN_W-1:0]   in_plen;
    logic                in_pfwd, in_tfwd;

    assign in_addr   = s_tdata[15:0];
    assign in_data   = s_tdata[31:16];
    assign in_left   = s_tdata[47:32];
    assign in_right  = s_tdata[63:48];
    assign in_skip   = s_tdata[79:64];
    assign in_anchor = s_tdata[89:80];
    assign in_plen   = s_tdata[100:90];
    assign in_pfwd   = s_tdata[101];
    assign in_tfwd   = s_tdata[102];

    logic [TL_W-1:0]     tl_reg;
    logic [IDX_W-1:0]    skip_reg, save_reg, rres_reg, lres_reg, left_reg, right_reg;
    logic [ANCHOR_W-1:0] anchor_reg;
    logic                pfwd_reg, tfwd_reg, miss_reg, slen_ok_reg;
    logic [POS_W-1:0]    need_reg, l_reg, len_reg, lp_reg, rp_reg;
    logic [IDX_W-1:0]    start_reg;
    rc_t                 rc_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    lout_reg, rout_reg;

    logic [IDX_W-1:0]    mid, idx, start_rd;
    logic [IDX_W:0]      sum_lr;
    logic [POS_W-1:0]    from, slen;
    logic [TEXT_AW-1:0]  t_addr;
    logic [PAT_AW-1:0]   p_addr, d_off;
    logic [CHAR_W-1:0]   pc, tc;

    // binary search midpoint and compare index
    assign sum_lr = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid    = sum_lr[IDX_W:1];
    always_comb begin
        case (cmd.idx_sel)
            IDX_LEFT:  idx = left_reg;
            IDX_RIGHT: idx = right_reg;
            default:   idx = mid;
        endcase
    end
    assign from = cmd.from_min ? ((lp_reg < rp_reg) ? lp_reg : rp_reg)
                               : {1'b0, skip_reg};

    // suffix length from the start position
    assign slen = ({1'b0, start_rd} < tl_reg) ? (tl_reg - {1'b0, start_rd}) : '0;

    // character addresses at the current position
    assign d_off  = l_reg[PAT_AW-1:0] - skip_reg[PAT_AW-1:0];
    assign p_addr = pfwd_reg ? (anchor_reg + d_off) : (anchor_reg - d_off);
    assign t_addr = tfwd_reg ? (start_reg + l_reg[TEXT_AW-1:0])
                  : (tl_reg[TEXT_AW-1:0] - TEXT_AW'(1) - start_reg - l_reg[TEXT_AW-1:0]);

    sais_ram #(.WIDTH(CHAR_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
        .aclk  (aclk),
        .we    (cmd.we_text),
        .waddr (in_addr[TEXT_AW-1:0]),
        .wdata (in_data[CHAR_W-1:0]),
        .raddr (t_addr),
        .rdata (tc)
    );

    sais_ram #(.WIDTH(IDX_W), .DEPTH(TEXT_DEPTH)) u_suffix_ram (
        .aclk  (aclk),
        .we    (cmd.we_suffix),
        .waddr (in_addr[TEXT_AW-1:0]),
        .wdata (in_data),
        .raddr (idx[TEXT_AW-1:0]),
        .rdata (start_rd)
    );

    sais_ram #(.WIDTH(CHAR_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
        .aclk  (aclk),
        .we    (cmd.we_pat),
        .waddr (in_addr[PAT_AW-1:0]),
        .wdata (in_data[CHAR_W-1:0]),
        .raddr (p_addr),
        .rdata (pc)
    );

    // status towards the controller
    assign stat.l_done  = (l_reg >= len_reg);
    assign stat.char_ne = (pc != tc);
    assign stat.rc      = rc_reg;
    assign stat.more    = ({1'b0, right_reg} > ({1'b0, left_reg} + 17'd1));

    // text length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tl_reg <= TL_W'(1);
        end else if (cfg_wr_en) begin
            tl_reg <= cfg_wr_data;
        end
    end

    // query, search and compare registers
    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            skip_reg   <= in_skip;
            anchor_reg <= in_anchor;
            pfwd_reg   <= in_pfwd;
            tfwd_reg   <= in_tfwd;
            need_reg   <= POS_W'(in_plen) + POS_W'(in_skip);
            save_reg   <= in_left;
            lres_reg   <= in_left;
            left_reg   <= in_left;
            right_reg  <= in_right;
            rres_reg   <= in_right;
            miss_reg   <= 1'b0;
        end
        if (cmd.cmp_start) begin
            start_reg   <= start_rd;
            len_reg     <= (need_reg < slen) ? need_reg : slen;
            slen_ok_reg <= (need_reg <= slen);
            l_reg       <= from;
        end
        if (cmd.eval_char) begin
            if (pc != tc) begin
                rc_reg <= (pc < tc) ? RC_LT : RC_GT;
            end else begin
                l_reg <= l_reg + POS_W'(1);
            end
        end
        if (cmd.end_cmp) begin
            rc_reg <= slen_ok_reg ? RC_EQ : RC_LT;
        end
        if (cmd.set_lp) lp_reg <= l_reg;
        if (cmd.set_rp) rp_reg <= l_reg;
        if (cmd.right_mid) right_reg <= mid;
        if (cmd.left_mid) left_reg <= mid;
        if (cmd.lres_right) lres_reg <= right_reg;
        if (cmd.upper_init) begin
            left_reg  <= save_reg;
            right_reg <= rres_reg;
        end
        if (cmd.rres_left) rres_reg <= left_reg;
        if (cmd.set_miss) miss_reg <= 1'b1;
        if (cmd.out_load) begin
            found_reg <= !miss_reg && (lres_reg <= rres_reg);
            lout_reg  <= (!miss_reg && (lres_reg <= rres_reg)) ? lres_reg : '0;
            rout_reg  <= (!miss_reg && (lres_reg <= rres_reg)) ? rres_reg : '0;
        end
    end

    assign m_tuser = found_reg;
    assign m_tdata = {rout_reg, lout_reg};
endmodule
`default_nettype wire

>>> rtl/suffix_array_interval_search.sv
// top level of the suffix array interval search
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  s_       | in        | address, data, interval_left,              | command
//           |           | interval_right, skip_offset, pattern_anchor,|
//           |           | pattern_length, pattern_forward,            |
//           |           | text_forward, pad bit                       |
//  m_       | out       | left_border, right_border                   | found
//  cfg_     | in        | text_length on cfg_wr_data                  | -
//
// a load word writes one store.
// a search runs through accept, the compares and an output step; a compare
// reads the suffix start, loads its length and first position, then evaluates
// characters one by one until the length is reached or a character differs.
// every compare of a midpoint, or of a right end that does not end the search,
// is followed by an interval check. the compares run one at a time through a
// single compare unit whose character reads go through registered ram ports.
// reset is synchronous active low; the stores are not cleared.
// a waiting result word holds while the next search runs; only the output
// cycle waits for m_tready, and no input word is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module suffix_array_interval_search (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sais_pkg::TL_W-1:0]       cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // address, data, interval_left, interval_right, skip_offset,
    // pattern_anchor, pattern_length, pattern_forward, text_forward
    input  wire logic [sais_pkg::S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic [sais_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // left_border, right_border
    output logic      [sais_pkg::M_TDATA_W-1:0]  m_tdata,
    // found
    output logic                                 m_tuser
);
    import sais_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller
    sais_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath
    sais_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );
endmodule
`default_nettype wire

>>> rtl/sais_checker.sv
// port checker of the interval search and its bind
`timescale 1ns / 1ps
`default_nettype none
module sais_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [sais_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sais_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tuser
);
    import sais_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // a miss carries zero borders
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero borders");

    // a hit has ordered borders
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[15:0] <= m_tdata[31:16])
        else $error("hit with reversed borders");

    // a search word makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_SEARCH |=> !s_tready)
        else $error("input taken during a search");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word after reset");
endmodule

bind suffix_array_interval_search sais_checker u_sais_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
